// ===== hdl/hlcu_pkg.sv =====
// Package for the HSV LED color update block: field widths, the reset saturation,
// the sequencer state and multiplier operand codes, and the FSM control/status structs.
// No dependencies; compile first.
`default_nettype none

package hlcu_pkg;

	localparam int SAMPLE_W = 10;
	localparam int CHAN_W   = 8;
	localparam int SAT_W    = 8;
	localparam int MUL_A_W  = 9;
	localparam int MUL_B_W  = 8;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

	localparam logic [SAT_W-1:0] SAT_RESET = 8'd255;

	// Hue sectors, taken from bits [9:8] of the scaled hue
	localparam logic [1:0] SECTOR_RG = 2'd0;
	localparam logic [1:0] SECTOR_GB = 2'd1;
	localparam logic [1:0] SECTOR_BR = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FS,
		ST_MUL_PB,
		ST_MUL_SB,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		OP_FRAC_SAT,
		OP_PROD_BRIGHT,
		OP_INV_BRIGHT
	} mul_op_t;

	typedef struct packed {
		logic in_valid;
		logic changed;
		logic color;
		logic out_free;
	} status_t;

	typedef struct packed {
		logic    in_ready;
		logic    mul_en;
		mul_op_t op;
		logic    x_load;
		logic    out_load;
	} ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/hlcu_in_if.sv =====
// Input channel: valid/ready handshake carrying one word of control samples.
// Depends on hlcu_pkg for field widths.
`default_nettype none

interface hlcu_in_if;
	import hlcu_pkg::*;

	logic                valid;
	logic                ready;
	logic                color_mode;
	logic [SAMPLE_W-1:0] brightness_sample;
	logic [SAMPLE_W-1:0] hue_sample;

	modport source (output valid, color_mode, brightness_sample, hue_sample, input ready);
	modport sink (input valid, color_mode, brightness_sample, hue_sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/hlcu_out_if.sv =====
// Output channel: valid/ready handshake carrying one RGB word.
// Depends on hlcu_pkg for field widths.
`default_nettype none

interface hlcu_out_if;
	import hlcu_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/hlcu_mul.sv =====
// Shared 9x8 unsigned multiplier with a registered product.
// Depends on hlcu_pkg for operand widths.
`default_nettype none

module hlcu_mul (
	input  wire                          clk,
	input  wire                          en,
	input  wire  [hlcu_pkg::MUL_A_W-1:0] a,
	input  wire  [hlcu_pkg::MUL_B_W-1:0] b,
	output logic [hlcu_pkg::MUL_P_W-1:0] p
);
	import hlcu_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

	assign p = p_q;
endmodule

`default_nettype wire

// ===== hdl/hlcu_fsm.sv =====
// Sequencer: in color mode steps the shared multiplier through the three products of the hue
// conversion, then hands the result to the output register. Depends on hlcu_pkg.
`default_nettype none

module hlcu_fsm (
	input  wire                clk,
	input  wire                arst_n,
	input  hlcu_pkg::status_t  st,
	output hlcu_pkg::ctrl_t    ctl
);
	import hlcu_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (st.in_valid && st.changed) begin
					state_d = st.color ? ST_MUL_FS : ST_FINISH;
				end
			end
			ST_MUL_FS: state_d = ST_MUL_PB;
			ST_MUL_PB: state_d = ST_MUL_SB;
			ST_MUL_SB: state_d = ST_FINISH;
			ST_FINISH: begin
				if (st.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.op       = OP_FRAC_SAT;
		unique case (state_q)
			ST_IDLE: ctl.in_ready = 1'b1;
			ST_MUL_FS: begin
				ctl.mul_en = 1'b1;
				ctl.op     = OP_FRAC_SAT;
			end
			ST_MUL_PB: begin
				ctl.mul_en = 1'b1;
				ctl.op     = OP_PROD_BRIGHT;
			end
			ST_MUL_SB: begin
				ctl.mul_en = 1'b1;
				ctl.op     = OP_INV_BRIGHT;
				ctl.x_load = 1'b1;
			end
			ST_FINISH: ctl.out_load = st.out_free;
			default: ctl = '0;
		endcase
	end
endmodule

`default_nettype wire

// ===== hdl/hsv_led_color_update_core.sv =====
// Top level of the HSV LED color update block: change detection, operand
// selection, channel assembly and the output register.
// Depends on hlcu_pkg, hlcu_in_if, hlcu_out_if, hlcu_mul and hlcu_fsm.
//
// Usage:
//   in_ch carries {color_mode, brightness_sample, hue_sample}; out_ch carries
//   {red, green, blue}. Both use valid/ready; a word moves when both are high.
//   A word is emitted only if it is the first after reset or if the mode, the
//   brightness sample or (in color mode) the hue sample changed; otherwise the
//   input word is dropped and in_ch.ready stays high.
//   Color mode: the word is accepted, the shared multiplier forms three products
//   in turn (frac*sat, that product*brightness, (256-sat)*brightness), and the
//   result is loaded into the output register once that register is free.
//   White mode: the word is accepted and the result goes straight to the output
//   register. in_ch.ready is high only while idle.
//   The output register holds a result while out_ch.ready is low; the next
//   input word is still taken and computed, and waits in its final step until
//   the output register frees.
//   cfg_we writes saturation from cfg_wdata; write only while idle.
//   Reset: saturation 255, first-word flag set, stored samples and mode zero,
//   output empty.
`default_nettype none

module hsv_led_color_update_core (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [hlcu_pkg::SAT_W-1:0]     cfg_wdata,
	hlcu_in_if.sink                        in_ch,
	hlcu_out_if.source                     out_ch
);
	import hlcu_pkg::*;

	logic [SAT_W-1:0]    sat_q;
	logic                first_q;
	logic                last_mode_q;
	logic [SAMPLE_W-1:0] last_bsamp_q;
	logic [SAMPLE_W-1:0] last_hsamp_q;
	logic [CHAN_W-1:0]   x_q;
	logic                out_valid_q;
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;

	status_t             st;
	ctrl_t               ctl;
	logic                accept;
	logic                changed;
	logic [CHAN_W-1:0]   bright;
	logic [SAMPLE_W+1:0] hue3;
	logic [SAMPLE_W-1:0] hue;
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_p;
	logic [8:0]          s_lvl;
	logic [9:0]          xs_sum;
	logic [CHAN_W-1:0]   lvl_lo;
	logic [CHAN_W-1:0]   lvl_mid;
	logic [CHAN_W-1:0]   lvl_hi;
	logic [CHAN_W-1:0]   red_d;
	logic [CHAN_W-1:0]   green_d;
	logic [CHAN_W-1:0]   blue_d;

	assign accept  = in_ch.valid && in_ch.ready;
	assign changed = first_q
		|| (in_ch.brightness_sample != last_bsamp_q)
		|| (in_ch.color_mode != last_mode_q)
		|| (in_ch.color_mode && (in_ch.hue_sample != last_hsamp_q));

	assign st.in_valid = in_ch.valid;
	assign st.changed  = changed;
	assign st.color    = in_ch.color_mode;
	assign st.out_free = !out_valid_q || out_ch.ready;

	hlcu_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctl    (ctl)
	);

	assign in_ch.ready = ctl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= SAT_RESET;
		end else if (cfg_we) begin
			sat_q <= cfg_wdata;
		end
	end

	// The stored samples double as the working operands of the current word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= 1'b1;
			last_mode_q  <= 1'b0;
			last_bsamp_q <= '0;
			last_hsamp_q <= '0;
		end else if (accept && changed) begin
			first_q      <= 1'b0;
			last_mode_q  <= in_ch.color_mode;
			last_bsamp_q <= in_ch.brightness_sample;
			last_hsamp_q <= in_ch.hue_sample;
		end
	end

	assign bright = last_bsamp_q[SAMPLE_W-1:2];
	// hue = sample * 3 / 4, 0..767
	assign hue3   = {1'b0, last_hsamp_q, 1'b0} + {2'b00, last_hsamp_q};
	assign hue    = hue3[SAMPLE_W+1:2];

	always_comb begin
		unique case (ctl.op)
			OP_FRAC_SAT: begin
				mul_a = {1'b0, hue[7:0]};
				mul_b = sat_q;
			end
			OP_PROD_BRIGHT: begin
				mul_a = {1'b0, mul_p[15:8]};
				mul_b = bright;
			end
			OP_INV_BRIGHT: begin
				mul_a = 9'd256 - {1'b0, sat_q};
				mul_b = bright;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	hlcu_mul u_mul (
		.clk (clk),
		.en  (ctl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// x = ((frac*sat >> 8) * bright) >> 8, captured before the product is reused
	always_ff @(posedge clk) begin
		if (ctl.x_load) begin
			x_q <= mul_p[15:8];
		end
	end

	assign s_lvl   = mul_p[16:8];
	assign xs_sum  = {2'b00, x_q} + {1'b0, s_lvl};
	assign lvl_lo  = s_lvl[7:0];
	assign lvl_mid = xs_sum[7:0];
	assign lvl_hi  = bright - x_q;

	always_comb begin
		if (!last_mode_q) begin
			red_d   = bright;
			green_d = bright;
			blue_d  = bright;
		end else begin
			case (hue[9:8])
				SECTOR_RG: begin
					red_d   = lvl_hi;
					green_d = lvl_mid;
					blue_d  = lvl_lo;
				end
				SECTOR_GB: begin
					red_d   = lvl_lo;
					green_d = lvl_hi;
					blue_d  = lvl_mid;
				end
				SECTOR_BR: begin
					red_d   = lvl_mid;
					green_d = lvl_lo;
					blue_d  = lvl_hi;
				end
				default: begin
					red_d   = lvl_hi;
					green_d = lvl_mid;
					blue_d  = lvl_lo;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.red   = red_q;
	assign out_ch.green = green_q;
	assign out_ch.blue  = blue_q;

	a_drop_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !changed |=> in_ch.ready)
		else $error("unchanged word left the block busy");

	a_change_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && changed |=> !in_ch.ready)
		else $error("changed word did not start work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ch.ready))
		else $error("output register overwritten while stalled");

	a_x_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load && last_mode_q |-> (x_q <= bright))
		else $error("hue offset exceeds brightness");

	a_first_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !first_q)
		else $error("result loaded with first-word flag still set");
endmodule

`default_nettype wire
